/* src/cata_pkg.sv */
// Shared types and constants for the client address table with aging.
// Used by every module of the block; depends on nothing else.
package cata_pkg;

   localparam int ADDR_W              = 32;
   localparam int TIMER_W             = 8;
   localparam int SLOT_W              = 5;
   localparam int LIMIT_W             = 5;
   localparam int CSR_DATA_W          = 8;
   localparam int DEFAULT_MAX_CLIENTS = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 5'd16;
   localparam logic [TIMER_W-1:0] REFRESH_RESET = 8'd20;

   // request function codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // configuration register indexes
   localparam logic CSR_CLIENT_LIMIT = 1'b0;
   localparam logic CSR_REFRESH_TIME = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [TIMER_W-1:0] timer;
   } entry_type;

   typedef struct packed {
      logic              load;
      logic [SLOT_W-1:0] slot;
      logic              refused;
   } rsp_load_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DECIDE,
      ST_DONE
   } state_type;

endpackage

/* src/cata_entry_mem.sv */
// Entry store: address and aging timer of each slot, one write and one read port.
// Read data is registered. Depends on cata_pkg.
module cata_entry_mem
   import cata_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_CLIENTS,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cata_rsp_reg.sv */
// Result output register: holds one finished response until the consumer takes it.
// Depends on cata_pkg.
module cata_rsp_reg
   import cata_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rsp_load_type      load,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SLOT_W-1:0] rsp_slot_number,
   output logic              rsp_refused
);

   logic              valid_ff, valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              refused_ff, refused_in;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in   = valid_ff && rsp_stall;
      slot_in    = slot_ff;
      refused_in = refused_ff;
      if (load.load && free) begin
         valid_in   = 1'b1;
         slot_in    = load.slot;
         refused_in = load.refused;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      refused_ff <= refused_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_slot_number = slot_ff;
   assign rsp_refused     = refused_ff;

endmodule

/* src/cata_ctrl.sv */
// Scan sequencer: walks the filled entries through the entry store, with a read
// state and an evaluate state per entry, and writes back timers and addresses.
// Depends on cata_pkg; drives cata_entry_mem and cata_rsp_reg.
module cata_ctrl
   import cata_pkg::*;
#(
   parameter int MAX_CLIENTS = DEFAULT_MAX_CLIENTS,
   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1,
   localparam int CNT_W = $clog2(MAX_CLIENTS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [ADDR_W-1:0]  req_client_address,
   input  logic [LIMIT_W-1:0] client_limit,
   input  logic [TIMER_W-1:0] refresh_time,
   output logic               rd_en,
   output logic [IDX_W-1:0]   rd_addr,
   input  entry_type          rd_data,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output entry_type          wr_data,
   input  logic               rsp_free,
   output rsp_load_type       rsp_load
);

   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               func_ff, func_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               exp_found_ff, exp_found_in;
   logic [IDX_W-1:0]   exp_idx_ff, exp_idx_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               refused_ff, refused_in;
   logic               last_entry;
   logic               table_full;

   assign last_entry = (CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff;
   assign table_full = (CMP_W'(fill_ff) >= CMP_W'(client_limit)) ||
                       (fill_ff == CNT_W'(MAX_CLIENTS));
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      func_in      = func_ff;
      addr_in      = addr_ff;
      exp_found_in = exp_found_ff;
      exp_idx_in   = exp_idx_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      refused_in   = refused_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '{addr: addr_ff, timer: refresh_time};
      rsp_load     = '{load: 1'b0, slot: slot_ff, refused: refused_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in      = req_func;
               addr_in      = req_client_address;
               idx_in       = '0;
               exp_found_in = 1'b0;
               if (fill_ff != '0) begin
                  state_in = ST_READ;
               end else if (req_func == FUNC_LOOKUP) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (func_ff == FUNC_TICK) begin
               // age this entry, stop at zero
               wr_en   = (rd_data.timer != '0);
               wr_data = '{addr: rd_data.addr, timer: rd_data.timer - TIMER_W'(1)};
               if (last_entry) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end else if (rd_data.addr == addr_ff) begin
               // hit: reload the timer and report this slot
               wr_en      = 1'b1;
               slot_in    = SLOT_W'(CNT_W'(idx_ff) + CNT_W'(1));
               refused_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               if (rd_data.timer == '0 && !exp_found_ff) begin
                  exp_found_in = 1'b1;
                  exp_idx_in   = idx_ff;
               end
               if (last_entry) begin
                  state_in = ST_DECIDE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_DECIDE: begin
            refused_in = 1'b0;
            if (!table_full) begin
               wr_en   = 1'b1;
               wr_addr = fill_ff[IDX_W-1:0];
               fill_in = fill_ff + CNT_W'(1);
               slot_in = SLOT_W'(fill_ff + CNT_W'(1));
            end else if (exp_found_ff) begin
               wr_en   = 1'b1;
               wr_addr = exp_idx_ff;
               slot_in = SLOT_W'(CNT_W'(exp_idx_ff) + CNT_W'(1));
            end else begin
               slot_in    = '0;
               refused_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_load.load = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      exp_found_ff <= exp_found_in;
      exp_idx_ff   <= exp_idx_in;
      slot_ff      <= slot_in;
      refused_ff   <= refused_in;
   end

`ifndef SYNTH
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_CLIENTS))
      else $error("fill count above capacity");

   a_fill_only_on_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DECIDE) |=> $stable(fill_ff))
      else $error("fill count changed outside append");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (rd_addr == wr_addr)))
      else $error("read and write of the same entry in one cycle");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_EVAL))
      else $error("read data not evaluated");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CNT_W'(idx_ff) < fill_ff))
      else $error("scan beyond filled entries");
`endif

endmodule

/* src/client_address_table_with_aging.sv */
// Client address table with aging. Keeps up to MAX_CLIENTS client addresses,
// each with an aging timer. A lookup request (func = 0) scans the filled slots
// in order: a hit reloads that slot's timer with refresh_time and returns the
// one-based slot; a miss appends while the fill count is below client_limit
// (values above MAX_CLIENTS act as MAX_CLIENTS), otherwise reuses the first
// slot whose timer is zero, otherwise returns slot 0 with refused set. A tick
// request (func = 1) decrements every nonzero timer and returns nothing.
// Entries live in a single-port-read, single-port-write store with a
// registered read; the sequencer passes through a read state and an evaluate
// state for each filled slot it scans. One request is processed at a time;
// the next is taken once the current result sits in the output register,
// which holds it while rsp_stall is high, or once a tick ends its pass.
// Configuration writes are always ready and must only be issued while idle.
// The store needs no clearing after reset: only filled slots are ever read.
module client_address_table_with_aging
   import cata_pkg::*;
#(
   parameter int MAX_CLIENTS = DEFAULT_MAX_CLIENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [ADDR_W-1:0]     req_client_address,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_W-1:0]     rsp_slot_number,
   output logic                  rsp_refused,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

   logic [LIMIT_W-1:0] client_limit_ff, client_limit_in;
   logic [TIMER_W-1:0] refresh_time_ff, refresh_time_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic               rsp_free;
   rsp_load_type       rsp_load;

   // Configuration registers: always ready, decode by index.
   assign csr_ready = 1'b1;

   always_comb begin
      client_limit_in = client_limit_ff;
      refresh_time_in = refresh_time_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLIENT_LIMIT: client_limit_in = csr_wdata[LIMIT_W-1:0];
            CSR_REFRESH_TIME: refresh_time_in = csr_wdata[TIMER_W-1:0];
            default: begin
               client_limit_in = client_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         client_limit_ff <= LIMIT_RESET;
         refresh_time_ff <= REFRESH_RESET;
      end else begin
         client_limit_ff <= client_limit_in;
         refresh_time_ff <= refresh_time_in;
      end
   end

   // Sequencer: accepts a request, scans the store, decides and writes back.
   cata_ctrl #(
      .MAX_CLIENTS(MAX_CLIENTS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_client_address (req_client_address),
      .client_limit       (client_limit_ff),
      .refresh_time       (refresh_time_ff),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rsp_free           (rsp_free),
      .rsp_load           (rsp_load)
   );

   // Entry store: address and timer per slot.
   cata_entry_mem #(
      .DEPTH(MAX_CLIENTS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Output register: hold the result until the consumer takes it.
   cata_rsp_reg u_rsp (
      .clock           (clock),
      .reset           (reset),
      .load            (rsp_load),
      .free            (rsp_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_number (rsp_slot_number),
      .rsp_refused     (rsp_refused)
   );

endmodule

/* tb/sv/client_address_table_with_aging_tb.sv */
// Self-checking bench for the client address table with aging: a directed
// script followed by randomised phases, each response checked against a model.
// Depends on cata_pkg and client_address_table_with_aging.
module client_address_table_with_aging_tb;
   import cata_pkg::*;

   localparam int MAX_CLIENTS     = DEFAULT_MAX_CLIENTS;
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 136;
   // a tick on a full table must finish its pass within this; leave margin on top
   localparam int SETTLE_CYCLES   = 60;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              refused;
   } grant_type;

   typedef enum logic { ROW_REQUEST, ROW_CSR_WRITE } row_kind_type;

   // one line of the directed script; 'typed' marks rows whose response is
   // written in by hand rather than taken from the predictor
   typedef struct packed {
      row_kind_type      kind;
      logic              func;
      logic              index;
      logic [ADDR_W-1:0] data;
      logic              typed;
      logic [SLOT_W-1:0] slot;
      logic              refused;
   } script_row_type;

   localparam int SCRIPT_LEN = 27;
   localparam script_row_type SCRIPT [0:SCRIPT_LEN-1] = '{
      // empty table with a limit of zero refuses a new client
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b1, 5'd0, 1'b1},
      '{ROW_REQUEST,   FUNC_TICK,   CSR_CLIENT_LIMIT, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
      // limit above capacity: append the address extremes, then hit them
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_001F, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b1, 5'd1, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'hFFFF_FFFF, 1'b1, 5'd2, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b1, 5'd1, 1'b0},
      '{ROW_REQUEST,   FUNC_TICK,   CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'hFFFF_FFFF, 1'b1, 5'd2, 1'b0},
      // full table, nothing expired: refuse
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0002, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'hA5A5_A5A5, 1'b1, 5'd0, 1'b1},
      // short refresh, let slot one expire, then reuse it
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_REFRESH_TIME, 32'h0000_0001, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b1, 5'd1, 1'b0},
      '{ROW_REQUEST,   FUNC_TICK,   CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h5A5A_5A5A, 1'b0, 5'd0, 1'b0},
      // refresh of zero: entries are expired as soon as they are loaded
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_REFRESH_TIME, 32'h0000_0000, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h1357_9BDF, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_TICK,   CSR_CLIENT_LIMIT, 32'h0000_0000, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0123_4567, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h89AB_CDEF, 1'b0, 5'd0, 1'b0},
      // limit lowered below the fill count: slot two must still be found
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0001, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b0},
      // all-ones write data: limit masks to five bits, refresh at its maximum
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_00FF, 1'b0, 5'd0, 1'b0},
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_REFRESH_TIME, 32'h0000_00FF, 1'b0, 5'd0, 1'b0},
      '{ROW_REQUEST,   FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'hDEAD_BEEF, 1'b0, 5'd0, 1'b0},
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_CLIENT_LIMIT, 32'h0000_0010, 1'b0, 5'd0, 1'b0},
      '{ROW_CSR_WRITE, FUNC_LOOKUP, CSR_REFRESH_TIME, 32'h0000_0014, 1'b0, 5'd0, 1'b0}
   };

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic                  req_func           = FUNC_LOOKUP;
   logic [ADDR_W-1:0]     req_client_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [SLOT_W-1:0]     rsp_slot_number;
   logic                  rsp_refused;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic                  csr_index          = CSR_CLIENT_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata          = '0;

   client_address_table_with_aging #(.MAX_CLIENTS(MAX_CLIENTS)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_client_address (req_client_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_refused        (rsp_refused),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Table mirror: addresses, timers, fill count and the two registers
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0]  tbl_addr  [MAX_CLIENTS];
   logic [TIMER_W-1:0] tbl_timer [MAX_CLIENTS];
   int unsigned        tbl_fill    = 0;
   logic [LIMIT_W-1:0] cfg_limit   = LIMIT_RESET;
   logic [TIMER_W-1:0] cfg_refresh = REFRESH_RESET;

   // grants still owed by the block, oldest first
   grant_type grants_due [$];
   int        mismatches        = 0;
   int        hold_off_asked    = 0;
   int        hold_off_served   = 0;

   // Apply one request to the mirror. A tick ages the filled slots and owes
   // nothing; a lookup owes exactly one grant.
   function automatic void resolve_client(input logic func, input logic [ADDR_W-1:0] addr,
                                          output bit owes, output grant_type grant);
      int unsigned lim;
      bit          found;
      found = 1'b0;
      grant = '0;
      owes  = 1'b0;
      if (func == FUNC_TICK) begin
         for (int i = 0; i < tbl_fill; i++)
            if (tbl_timer[i] != '0)
               tbl_timer[i] = tbl_timer[i] - 1'b1;
         return;
      end
      owes = 1'b1;
      // hit: reload the timer of the first matching slot
      for (int i = 0; i < tbl_fill && !found; i++) begin
         if (tbl_addr[i] == addr) begin
            tbl_timer[i] = cfg_refresh;
            grant.slot   = SLOT_W'(i + 1);
            found        = 1'b1;
         end
      end
      if (found)
         return;
      lim = (cfg_limit > MAX_CLIENTS) ? MAX_CLIENTS : cfg_limit;
      if (tbl_fill >= lim) begin
         // table counts as full: take over the first expired slot, if any
         for (int i = 0; i < tbl_fill && !found; i++) begin
            if (tbl_timer[i] == '0) begin
               tbl_addr[i]  = addr;
               tbl_timer[i] = cfg_refresh;
               grant.slot   = SLOT_W'(i + 1);
               found        = 1'b1;
            end
         end
         if (!found)
            grant.refused = 1'b1;
      end else begin
         tbl_addr[tbl_fill]  = addr;
         tbl_timer[tbl_fill] = cfg_refresh;
         tbl_fill            = tbl_fill + 1;
         grant.slot          = SLOT_W'(tbl_fill);
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one request and hold it until it is taken. Valid stays high on
   // return, so a burst simply carries on with the next call.
   task automatic send_request(input logic func, input logic [ADDR_W-1:0] addr,
                               input bit typed, input grant_type typed_grant);
      bit        owes;
      grant_type grant;
      req_valid          <= 1'b1;
      req_func           <= func;
      req_client_address <= addr;
      do @(posedge clock); while (req_stall);
      resolve_client(func, addr, owes, grant);
      if (owes)
         grants_due.push_back(typed ? typed_grant : grant);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles != 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed grant has come back.
   task automatic drain_grants();
      req_valid <= 1'b0;
      do @(posedge clock); while (grants_due.size() != 0);
   endtask

   // Write a register only once the block is idle: drain, then allow a tick
   // that owes nothing to finish its pass over the table.
   task automatic write_register(input logic index, input logic [CSR_DATA_W-1:0] value);
      drain_grants();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_CLIENT_LIMIT)
         cfg_limit = value[LIMIT_W-1:0];
      else
         cfg_refresh = value[TIMER_W-1:0];
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: stall in stretches of random mode, plus one long hold
   // ---------------------------------------------------------------------
   initial begin : receiver
      int  mode;
      int  stretch_left;
      int  hold_left;
      int  beat;
      bit  stall_next;
      mode         = 0;
      stretch_left = 0;
      hold_left    = 0;
      beat         = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_off_asked != hold_off_served) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_served++;
         end
         if (stretch_left == 0) begin
            mode         = $urandom_range(0, 3);
            stretch_left = $urandom_range(20, 200);
         end
         stretch_left--;
         beat++;
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (mode)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 3) == 0);
               2: stall_next = ($urandom_range(0, 3) != 0);
               default: stall_next = ((beat % 5) < 2);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: compare each taken response with the oldest grant
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grants_due.size() == 0) begin
            report_mismatch($sformatf("response slot_number=%0d refused=%0d with none pending",
                                      rsp_slot_number, rsp_refused));
         end else begin
            want = grants_due.pop_front();
            if (rsp_slot_number !== want.slot)
               report_mismatch($sformatf("slot_number expected %0d, got %0d",
                                         want.slot, rsp_slot_number));
            if (rsp_refused !== want.refused)
               report_mismatch($sformatf("refused expected %0d, got %0d",
                                         want.refused, rsp_refused));
         end
      end
   end

   // Watchdog: give up after a long run of cycles in which nothing moves.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("client_address_table_with_aging_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      grant_type         typed_grant;
      logic [ADDR_W-1:0] pool [32];
      int                pool_n;
      int                tick_pct;
      int                burst_left;
      bit                gappy;
      logic [CSR_DATA_W-1:0] limit_val;
      logic [CSR_DATA_W-1:0] refresh_val;
      logic              func;
      logic [ADDR_W-1:0] addr;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script: registers are written idle, requests back to back
      // or with short random gaps
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         if (SCRIPT[r].kind == ROW_CSR_WRITE) begin
            write_register(SCRIPT[r].index, SCRIPT[r].data[CSR_DATA_W-1:0]);
         end else begin
            typed_grant.slot    = SCRIPT[r].slot;
            typed_grant.refused = SCRIPT[r].refused;
            send_request(SCRIPT[r].func, SCRIPT[r].data, SCRIPT[r].typed, typed_grant);
            pause_sender($urandom_range(0, 3));
         end
      end

      // random phases: each picks a limit and a refresh time (cycling through
      // the extremes), a pool of clients to revisit and a tick rate
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 6)
            0: limit_val = 8'd16;
            1: limit_val = 8'd0;
            2: limit_val = CSR_DATA_W'($urandom_range(2, 15));
            3: limit_val = 8'hFF;
            4: limit_val = 8'd1;
            default: limit_val = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         case ((phase + 3) % 6)
            0: refresh_val = 8'd0;
            1: refresh_val = 8'd1;
            2: refresh_val = 8'hFF;
            3: refresh_val = CSR_DATA_W'($urandom_range(2, 6));
            4: refresh_val = CSR_DATA_W'($urandom_range(7, 40));
            default: refresh_val = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 1)) begin
            write_register(CSR_CLIENT_LIMIT, limit_val);
            write_register(CSR_REFRESH_TIME, refresh_val);
         end else begin
            write_register(CSR_REFRESH_TIME, refresh_val);
            write_register(CSR_CLIENT_LIMIT, limit_val);
         end

         pool_n   = (phase == 0) ? 24 : $urandom_range(2, 24);
         tick_pct = $urandom_range(10, 40);
         for (int p = 0; p < pool_n; p++)
            pool[p] = $urandom;

         // every third phase runs without sender gaps
         gappy      = (phase % 3) != 0;
         burst_left = 0;

         // hold the receiver off while requests keep coming, so the block
         // backs up and stalls its input
         if (phase == 3)
            hold_off_asked++;

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k == ITEMS_PER_PHASE / 2 && (phase % 4) == 1)
               drain_grants();
            if (burst_left == 0) begin
               if (gappy)
                  pause_sender($urandom_range(0, 10));
               burst_left = $urandom_range(1, 16);
            end
            // mostly revisit known clients; the rest are fresh addresses
            if ($urandom_range(0, 99) < tick_pct) begin
               func = FUNC_TICK;
               addr = $urandom;
            end else begin
               func = FUNC_LOOKUP;
               if ($urandom_range(0, 99) < 80)
                  addr = pool[$urandom_range(0, pool_n - 1)];
               else
                  addr = $urandom;
            end
            send_request(func, addr, 1'b0, '0);
            burst_left--;
         end
      end

      drain_grants();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && grants_due.size() == 0)
         $display("client_address_table_with_aging_tb passed");
      else
         $display("client_address_table_with_aging_tb failed");
      $finish;
   end

endmodule
